@@ hw/rtl/sc1kd_pkg.sv @@
// Package for the scancode set 1 key decoder: key numbers, prefix codes,
// event and result types, and the scancode and character tables.
// No dependencies.
`default_nettype none

package sc1kd_pkg;

   // Prefix and sequence bytes
   localparam logic [7:0] SC_E0        = 8'hE0;
   localparam logic [7:0] SC_E1        = 8'hE1;
   localparam logic [7:0] SC_PRT_MAKE1 = 8'h2A;
   localparam logic [7:0] SC_PRT_MAKE2 = 8'h37;
   localparam logic [7:0] SC_PRT_BRK1  = 8'hB7;
   localparam logic [7:0] SC_PRT_BRK2  = 8'hAA;
   localparam logic [7:0] SC_BREAK_BIT = 8'h80;
   localparam logic [7:0] SC_MAKE_MASK = 8'h7F;

   localparam int unsigned PAUSE_LEN = 5;

   // Key numbers
   localparam logic [6:0] K_NONE        = 7'd0;
   localparam logic [6:0] K_ESC         = 7'd1;
   localparam logic [6:0] K_BACKSPACE   = 7'd2;
   localparam logic [6:0] K_TAB         = 7'd3;
   localparam logic [6:0] K_ENTER       = 7'd4;
   localparam logic [6:0] K_SPACE       = 7'd5;
   localparam logic [6:0] K_LSHIFT      = 7'd6;
   localparam logic [6:0] K_RSHIFT      = 7'd7;
   localparam logic [6:0] K_LCTRL       = 7'd8;
   localparam logic [6:0] K_RCTRL       = 7'd9;
   localparam logic [6:0] K_LALT        = 7'd10;
   localparam logic [6:0] K_RALT        = 7'd11;
   localparam logic [6:0] K_CAPSLOCK    = 7'd12;
   localparam logic [6:0] K_NUMLOCK     = 7'd13;
   localparam logic [6:0] K_SCROLLLOCK  = 7'd14;
   localparam logic [6:0] K_F1          = 7'd15;
   localparam logic [6:0] K_DIGIT1      = 7'd27;
   localparam logic [6:0] K_SLASH       = 7'd47;
   localparam logic [6:0] K_A           = 7'd48;
   localparam logic [6:0] K_Z           = 7'd73;
   localparam logic [6:0] K_KP0         = 7'd74;
   localparam logic [6:0] K_KP9         = 7'd83;
   localparam logic [6:0] K_KPDOT       = 7'd84;
   localparam logic [6:0] K_KPASTERISK  = 7'd85;
   localparam logic [6:0] K_KPMINUS     = 7'd86;
   localparam logic [6:0] K_KPPLUS      = 7'd87;
   localparam logic [6:0] K_KPENTER     = 7'd88;
   localparam logic [6:0] K_KPSLASH     = 7'd89;
   localparam logic [6:0] K_UP          = 7'd90;
   localparam logic [6:0] K_DOWN        = 7'd91;
   localparam logic [6:0] K_LEFT        = 7'd92;
   localparam logic [6:0] K_RIGHT       = 7'd93;
   localparam logic [6:0] K_HOME        = 7'd94;
   localparam logic [6:0] K_END         = 7'd95;
   localparam logic [6:0] K_PAGEUP      = 7'd96;
   localparam logic [6:0] K_PAGEDOWN    = 7'd97;
   localparam logic [6:0] K_INSERT      = 7'd98;
   localparam logic [6:0] K_DELETE      = 7'd99;
   localparam logic [6:0] K_PRINTSCREEN = 7'd100;
   localparam logic [6:0] K_PAUSE       = 7'd101;

   // Characters
   localparam logic [6:0] CH_NONE  = 7'h00;
   localparam logic [6:0] CH_BS    = 7'h08;
   localparam logic [6:0] CH_TAB   = 7'h09;
   localparam logic [6:0] CH_NL    = 7'h0A;
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_STAR  = 7'h2A;
   localparam logic [6:0] CH_PLUS  = 7'h2B;
   localparam logic [6:0] CH_MINUS = 7'h2D;
   localparam logic [6:0] CH_DOT   = 7'h2E;
   localparam logic [6:0] CH_SLASH = 7'h2F;
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_UPPER = 7'h41;
   localparam logic [6:0] CH_LOWER = 7'h61;

   // Modifier and lock bit positions
   localparam int unsigned MOD_SHIFT = 0;
   localparam int unsigned MOD_CTRL  = 1;
   localparam int unsigned MOD_LALT  = 2;
   localparam int unsigned MOD_ALTGR = 3;
   localparam int unsigned LCK_SCROLL = 0;
   localparam int unsigned LCK_NUM    = 1;
   localparam int unsigned LCK_CAPS   = 2;

   typedef enum logic [1:0] {
      PRT_IDLE,
      PRT_FIRST,
      PRT_SECOND
   } print_state_type;

   typedef struct packed {
      logic       valid;
      logic [6:0] key;
      logic       pressed;
      logic       e0;
      logic       e1;
      logic [6:0] make;
   } key_event_type;

   // Result word, lowest field in the lowest bits
   typedef struct packed {
      logic       leds_changed;
      logic [6:0] ascii_char;
      logic [2:0] lock_states;
      logic [3:0] held_modifiers;
      logic [6:0] make_code;
      logic       extended_e1;
      logic       extended_e0;
      logic       key_pressed;
      logic [6:0] key_code;
   } rsp_word_type;

   function automatic logic [7:0] pause_byte(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = 8'h1D;
         3'd1:    r = 8'h45;
         3'd2:    r = 8'hE1;
         3'd3:    r = 8'h9D;
         3'd4:    r = 8'hC5;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] base_key(input logic [6:0] mk);
      logic [6:0] k;
      case (mk)
         7'h01: k = K_ESC;
         7'h0E: k = K_BACKSPACE;
         7'h0F: k = K_TAB;
         7'h1C: k = K_ENTER;
         7'h39: k = K_SPACE;
         7'h2A: k = K_LSHIFT;
         7'h36: k = K_RSHIFT;
         7'h1D: k = K_LCTRL;
         7'h38: k = K_LALT;
         7'h3A: k = K_CAPSLOCK;
         7'h45: k = K_NUMLOCK;
         7'h46: k = K_SCROLLLOCK;
         7'h3B: k = K_F1 + 7'd0;
         7'h3C: k = K_F1 + 7'd1;
         7'h3D: k = K_F1 + 7'd2;
         7'h3E: k = K_F1 + 7'd3;
         7'h3F: k = K_F1 + 7'd4;
         7'h40: k = K_F1 + 7'd5;
         7'h41: k = K_F1 + 7'd6;
         7'h42: k = K_F1 + 7'd7;
         7'h43: k = K_F1 + 7'd8;
         7'h44: k = K_F1 + 7'd9;
         7'h57: k = K_F1 + 7'd10;
         7'h58: k = K_F1 + 7'd11;
         7'h02: k = K_DIGIT1 + 7'd0;
         7'h03: k = K_DIGIT1 + 7'd1;
         7'h04: k = K_DIGIT1 + 7'd2;
         7'h05: k = K_DIGIT1 + 7'd3;
         7'h06: k = K_DIGIT1 + 7'd4;
         7'h07: k = K_DIGIT1 + 7'd5;
         7'h08: k = K_DIGIT1 + 7'd6;
         7'h09: k = K_DIGIT1 + 7'd7;
         7'h0A: k = K_DIGIT1 + 7'd8;
         7'h0B: k = K_DIGIT1 + 7'd9;
         7'h0C: k = K_DIGIT1 + 7'd10;
         7'h0D: k = K_DIGIT1 + 7'd11;
         7'h1A: k = K_DIGIT1 + 7'd12;
         7'h1B: k = K_DIGIT1 + 7'd13;
         7'h2B: k = K_DIGIT1 + 7'd14;
         7'h27: k = K_DIGIT1 + 7'd15;
         7'h28: k = K_DIGIT1 + 7'd16;
         7'h29: k = K_DIGIT1 + 7'd17;
         7'h33: k = K_DIGIT1 + 7'd18;
         7'h34: k = K_DIGIT1 + 7'd19;
         7'h35: k = K_SLASH;
         7'h1E: k = K_A + 7'd0;
         7'h30: k = K_A + 7'd1;
         7'h2E: k = K_A + 7'd2;
         7'h20: k = K_A + 7'd3;
         7'h12: k = K_A + 7'd4;
         7'h21: k = K_A + 7'd5;
         7'h22: k = K_A + 7'd6;
         7'h23: k = K_A + 7'd7;
         7'h17: k = K_A + 7'd8;
         7'h24: k = K_A + 7'd9;
         7'h25: k = K_A + 7'd10;
         7'h26: k = K_A + 7'd11;
         7'h32: k = K_A + 7'd12;
         7'h31: k = K_A + 7'd13;
         7'h18: k = K_A + 7'd14;
         7'h19: k = K_A + 7'd15;
         7'h10: k = K_A + 7'd16;
         7'h13: k = K_A + 7'd17;
         7'h1F: k = K_A + 7'd18;
         7'h14: k = K_A + 7'd19;
         7'h16: k = K_A + 7'd20;
         7'h2F: k = K_A + 7'd21;
         7'h11: k = K_A + 7'd22;
         7'h2D: k = K_A + 7'd23;
         7'h15: k = K_A + 7'd24;
         7'h2C: k = K_Z;
         7'h52: k = K_KP0 + 7'd0;
         7'h4F: k = K_KP0 + 7'd1;
         7'h50: k = K_KP0 + 7'd2;
         7'h51: k = K_KP0 + 7'd3;
         7'h4B: k = K_KP0 + 7'd4;
         7'h4C: k = K_KP0 + 7'd5;
         7'h4D: k = K_KP0 + 7'd6;
         7'h47: k = K_KP0 + 7'd7;
         7'h48: k = K_KP0 + 7'd8;
         7'h49: k = K_KP9;
         7'h53: k = K_KPDOT;
         7'h37: k = K_KPASTERISK;
         7'h4A: k = K_KPMINUS;
         7'h4E: k = K_KPPLUS;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [6:0] ext_key(input logic [6:0] mk);
      logic [6:0] k;
      case (mk)
         7'h48: k = K_UP;
         7'h50: k = K_DOWN;
         7'h4B: k = K_LEFT;
         7'h4D: k = K_RIGHT;
         7'h47: k = K_HOME;
         7'h4F: k = K_END;
         7'h49: k = K_PAGEUP;
         7'h51: k = K_PAGEDOWN;
         7'h52: k = K_INSERT;
         7'h53: k = K_DELETE;
         7'h1D: k = K_RCTRL;
         7'h38: k = K_RALT;
         7'h1C: k = K_KPENTER;
         7'h35: k = K_KPSLASH;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   // Digit and punctuation row, plain and shifted
   function automatic logic [6:0] sym_char(input logic [4:0] idx, input logic shift);
      logic [6:0] p;
      logic [6:0] s;
      case (idx)
         5'd0:    begin p = 7'h31; s = 7'h21; end
         5'd1:    begin p = 7'h32; s = 7'h40; end
         5'd2:    begin p = 7'h33; s = 7'h23; end
         5'd3:    begin p = 7'h34; s = 7'h24; end
         5'd4:    begin p = 7'h35; s = 7'h25; end
         5'd5:    begin p = 7'h36; s = 7'h5E; end
         5'd6:    begin p = 7'h37; s = 7'h26; end
         5'd7:    begin p = 7'h38; s = 7'h2A; end
         5'd8:    begin p = 7'h39; s = 7'h28; end
         5'd9:    begin p = 7'h30; s = 7'h29; end
         5'd10:   begin p = 7'h2D; s = 7'h5F; end
         5'd11:   begin p = 7'h3D; s = 7'h2B; end
         5'd12:   begin p = 7'h5B; s = 7'h7B; end
         5'd13:   begin p = 7'h5D; s = 7'h7D; end
         5'd14:   begin p = 7'h5C; s = 7'h7C; end
         5'd15:   begin p = 7'h3B; s = 7'h3A; end
         5'd16:   begin p = 7'h27; s = 7'h22; end
         5'd17:   begin p = 7'h60; s = 7'h7E; end
         5'd18:   begin p = 7'h2C; s = 7'h3C; end
         5'd19:   begin p = 7'h2E; s = 7'h3E; end
         5'd20:   begin p = 7'h2F; s = 7'h3F; end
         default: begin p = CH_NONE; s = CH_NONE; end
      endcase
      return shift ? s : p;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scancode_set1_key_decoder_unit.sv @@
// Top level of the scancode set 1 key decoder: input register, prefix
// tracker, key state and result register.
// Depends on sc1kd_pkg, sc1kd_seq_tracker and sc1kd_key_state.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_tvalid/tready  | req_tdata[7:0]  scan byte
//   rsp     | out | rsp_tvalid/tready  | rsp_tdata[31:0] key event
//
// One byte is accepted per cycle while the result side is not stalled; the accepting edge
// loads the input register, from which its event, if any, is loaded into the result register.
// State updates as a byte leaves the input register, so bytes chain back to back.
// Reset clears prefix, modifier and lock state; no clearing pass.
// A stalled result holds the input register; one more byte can wait there.
`default_nettype none

module scancode_set1_key_decoder_unit
   import sc1kd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] scan_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [6:0] key_code, [7] key_pressed,
                                         // [8] extended_e0, [9] extended_e1,
                                         // [16:10] make_code, [20:17] held_modifiers,
                                         // [23:21] lock_states, [30:24] ascii_char,
                                         // [31] leds_changed
);

   logic         s1_valid_ff, s1_valid_in;
   logic [7:0]   s1_byte_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;

   logic          advance;
   logic          req_accept;
   key_event_type evt;
   rsp_word_type  rsp_word;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   sc1kd_seq_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .scan_byte (s1_byte_ff),
      .evt       (evt)
   );

   sc1kd_key_state u_key_state (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .evt      (evt),
      .rsp_word (rsp_word)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && evt.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_tdata;
      end
      if (advance && evt.valid) begin
         rsp_word_ff <= rsp_word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

   // Hold the pending byte while the result side is stalled
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_byte_ff)))
      else $error("pending scan byte lost under stall");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !advance)
      else $error("result register overwritten while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input refused with empty input register");

endmodule

`default_nettype wire

@@ hw/rtl/sc1kd_seq_tracker.sv @@
// Prefix tracker for the scancode set 1 key decoder: E0, E1 pause and
// print screen sequences; turns one byte into zero or one key event.
// Depends on sc1kd_pkg.
`default_nettype none

module sc1kd_seq_tracker
   import sc1kd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  wire logic [7:0]    scan_byte,
   output key_event_type      evt
);

   logic            e0_pending_ff, e0_pending_in;
   logic            e1_pending_ff, e1_pending_in;
   logic [2:0]      pause_count_ff, pause_count_in;
   logic            pause_match_ff, pause_match_in;
   print_state_type print_state_ff, print_state_in;
   logic            print_make_ff, print_make_in;

   logic [6:0] make;
   logic       pressed;
   logic       byte_ok;
   logic       last_pause;

   assign make       = scan_byte[6:0] & SC_MAKE_MASK[6:0];
   assign pressed    = (scan_byte & SC_BREAK_BIT) == 8'h00;
   assign byte_ok    = (scan_byte == pause_byte(pause_count_ff)) &&
                       ((pause_count_ff == 3'd0) || pause_match_ff);
   assign last_pause = pause_count_ff == 3'(PAUSE_LEN - 1);

   // Next state
   always_comb begin
      e0_pending_in  = e0_pending_ff;
      e1_pending_in  = e1_pending_ff;
      pause_count_in = pause_count_ff;
      pause_match_in = pause_match_ff;
      print_state_in = print_state_ff;
      print_make_in  = print_make_ff;
      if (e1_pending_ff) begin
         pause_match_in = byte_ok;
         if (last_pause) begin
            e1_pending_in  = 1'b0;
            pause_count_in = 3'd0;
         end else begin
            pause_count_in = pause_count_ff + 3'd1;
         end
      end else if (e0_pending_ff && (print_state_ff != PRT_IDLE)) begin
         if ((print_state_ff == PRT_FIRST) && (scan_byte == SC_E0)) begin
            print_state_in = PRT_SECOND;
         end else begin
            e0_pending_in  = 1'b0;
            print_state_in = PRT_IDLE;
         end
      end else if (scan_byte == SC_E0) begin
         e0_pending_in = 1'b1;
      end else if (scan_byte == SC_E1) begin
         e1_pending_in  = 1'b1;
         pause_count_in = 3'd0;
      end else if (e0_pending_ff) begin
         if ((scan_byte == SC_PRT_MAKE1) || (scan_byte == SC_PRT_BRK1)) begin
            print_make_in  = scan_byte == SC_PRT_MAKE1;
            print_state_in = PRT_FIRST;
         end else begin
            e0_pending_in = 1'b0;
         end
      end
   end

   // Event outputs
   always_comb begin
      evt = '{valid: 1'b0, key: K_NONE, pressed: pressed, e0: 1'b0, e1: 1'b0,
              make: make};
      if (e1_pending_ff) begin
         if (last_pause && byte_ok) begin
            evt = '{valid: 1'b1, key: K_PAUSE, pressed: 1'b1, e0: 1'b0, e1: 1'b1,
                    make: 7'd0};
         end
      end else if (e0_pending_ff && (print_state_ff != PRT_IDLE)) begin
         if (print_state_ff == PRT_SECOND) begin
            if (print_make_ff && (scan_byte == SC_PRT_MAKE2)) begin
               evt = '{valid: 1'b1, key: K_PRINTSCREEN, pressed: 1'b1, e0: 1'b1,
                       e1: 1'b0, make: 7'd0};
            end else if (!print_make_ff && (scan_byte == SC_PRT_BRK2)) begin
               evt = '{valid: 1'b1, key: K_PRINTSCREEN, pressed: 1'b0, e0: 1'b1,
                       e1: 1'b0, make: 7'd0};
            end
         end
      end else if ((scan_byte == SC_E0) || (scan_byte == SC_E1)) begin
         evt.valid = 1'b0;
      end else if (e0_pending_ff) begin
         if ((scan_byte != SC_PRT_MAKE1) && (scan_byte != SC_PRT_BRK1)) begin
            evt.valid = 1'b1;
            evt.key   = ext_key(make);
            evt.e0    = 1'b1;
         end
      end else begin
         evt.valid = 1'b1;
         evt.key   = base_key(make);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_pending_ff  <= 1'b0;
         e1_pending_ff  <= 1'b0;
         pause_count_ff <= 3'd0;
         print_state_ff <= PRT_IDLE;
      end else if (step_en) begin
         e0_pending_ff  <= e0_pending_in;
         e1_pending_ff  <= e1_pending_in;
         pause_count_ff <= pause_count_in;
         print_state_ff <= print_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         pause_match_ff <= pause_match_in;
         print_make_ff  <= print_make_in;
      end
   end

   a_pause_count_range: assert property (@(posedge clock) disable iff (reset)
      pause_count_ff <= 3'(PAUSE_LEN - 1))
      else $error("pause byte count out of range");

   a_print_needs_e0: assert property (@(posedge clock) disable iff (reset)
      (print_state_ff != PRT_IDLE) |-> (e0_pending_ff && !e1_pending_ff))
      else $error("print screen sequence without E0 or inside pause");

   a_pause_ends_full: assert property (@(posedge clock) disable iff (reset)
      ($fell(e1_pending_ff) && !$past(reset)) |->
         ($past(pause_count_ff) == 3'(PAUSE_LEN - 1)))
      else $error("pause collection ended early");

endmodule

`default_nettype wire

@@ hw/rtl/sc1kd_key_state.sv @@
// Modifier and lock tracking plus ASCII mapping for the scancode set 1
// key decoder; builds the result word for one key event.
// Depends on sc1kd_pkg.
`default_nettype none

module sc1kd_key_state
   import sc1kd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  wire key_event_type evt,
   output rsp_word_type       rsp_word
);

   logic [3:0] held_ff, held_in;
   logic [2:0] lock_ff, lock_in;
   logic       leds;
   logic [6:0] ascii;
   logic [4:0] sym_idx;
   logic [6:0] key_off_a;
   logic [6:0] key_off_kp;

   always_comb begin
      held_in = held_ff;
      lock_in = lock_ff;
      leds    = 1'b0;
      case (evt.key)
         K_LSHIFT, K_RSHIFT: held_in[MOD_SHIFT] = evt.pressed;
         K_LCTRL, K_RCTRL:   held_in[MOD_CTRL]  = evt.pressed;
         K_LALT:             held_in[MOD_LALT]  = evt.pressed;
         K_RALT:             held_in[MOD_ALTGR] = evt.pressed;
         K_CAPSLOCK: begin
            lock_in[LCK_CAPS] = lock_ff[LCK_CAPS] ^ evt.pressed;
            leds              = evt.pressed;
         end
         K_NUMLOCK: begin
            lock_in[LCK_NUM] = lock_ff[LCK_NUM] ^ evt.pressed;
            leds             = evt.pressed;
         end
         K_SCROLLLOCK: begin
            lock_in[LCK_SCROLL] = lock_ff[LCK_SCROLL] ^ evt.pressed;
            leds                = evt.pressed;
         end
         default: leds = 1'b0;
      endcase
   end

   assign key_off_a  = evt.key - K_A;
   assign key_off_kp = evt.key - K_KP0;
   assign sym_idx    = 5'(evt.key - K_DIGIT1);

   // Map with the flags as they stand after this event
   always_comb begin
      ascii = CH_NONE;
      if ((evt.key == K_ENTER) || (evt.key == K_KPENTER)) begin
         ascii = CH_NL;
      end else if (evt.key == K_TAB) begin
         ascii = CH_TAB;
      end else if (evt.key == K_BACKSPACE) begin
         ascii = CH_BS;
      end else if (evt.key == K_SPACE) begin
         ascii = CH_SPACE;
      end else if (evt.key inside {[K_A:K_Z]}) begin
         ascii = ((held_in[MOD_SHIFT] ^ lock_in[LCK_CAPS]) ? CH_UPPER : CH_LOWER)
                 + key_off_a;
      end else if (evt.key inside {[K_DIGIT1:K_SLASH]}) begin
         ascii = sym_char(sym_idx, held_in[MOD_SHIFT]);
      end else if (evt.key inside {[K_KP0:K_KP9]}) begin
         ascii = lock_in[LCK_NUM] ? (CH_ZERO + key_off_kp) : CH_NONE;
      end else if (evt.key == K_KPDOT) begin
         ascii = lock_in[LCK_NUM] ? CH_DOT : CH_NONE;
      end else if (evt.key == K_KPPLUS) begin
         ascii = CH_PLUS;
      end else if (evt.key == K_KPMINUS) begin
         ascii = CH_MINUS;
      end else if (evt.key == K_KPASTERISK) begin
         ascii = CH_STAR;
      end else if (evt.key == K_KPSLASH) begin
         ascii = CH_SLASH;
      end
   end

   assign rsp_word = '{leds_changed: leds, ascii_char: ascii, lock_states: lock_in,
                       held_modifiers: held_in, make_code: evt.make,
                       extended_e1: evt.e1, extended_e0: evt.e0,
                       key_pressed: evt.pressed, key_code: evt.key};

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 4'd0;
         lock_ff <= 3'd0;
      end else if (step_en && evt.valid) begin
         held_ff <= held_in;
         lock_ff <= lock_in;
      end
   end

endmodule

`default_nettype wire
